// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared helpers for concurrent assertions in the scheduler RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define ASSERT_SAME(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ----- hdl/srtf_pkg.sv -----
// ----------------------------------------------------------------------------
// Scheduler package
// Request opcodes, result codes and fixed limits of the shortest-remaining-time scheduler.
// ----------------------------------------------------------------------------
package srtf_pkg;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_TICK = 1'b1;

   localparam logic [1:0] KIND_LOAD_OK     = 2'd0;
   localparam logic [1:0] KIND_LOAD_REJECT = 2'd1;
   localparam logic [1:0] KIND_IDLE_TICK   = 2'd2;
   localparam logic [1:0] KIND_RAN         = 2'd3;

   localparam logic [13:0] BURST_LIMIT = 14'd10000;
   localparam logic [15:0] TIME_MAX    = 16'hFFFF;
   localparam logic [15:0] WAIT_MAX    = 16'hFFFF;

endpackage

// ----- hdl/srtf_scheduler_tick.sv -----
// ----------------------------------------------------------------------------
// Shortest-remaining-time-first scheduler
// Loads process entries and advances one scheduling tick per request.
// ----------------------------------------------------------------------------
// A load request goes from the idle state to the finish state, and its response
// is registered once the output register is free. A tick request walks the
// process table through one registered read port per table, first to find the
// ready process with the least remaining time and then, if one was found, a
// second time to update waiting counts and the selected entry. One request is
// in flight at a time; the response sits in an output register until it is
// taken.
module srtf_scheduler_tick #(
   parameter int MAX_PROCS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_op,
   input  logic [15:0] req_arrival,
   input  logic [13:0] req_burst,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [3:0]  rsp_proc_id,
   output logic [15:0] rsp_tick_time,
   output logic        rsp_finished,
   output logic [15:0] rsp_finish_time,
   output logic [15:0] rsp_wait_total,
   output logic        rsp_all_done
);

`include "assert_macros.svh"

   localparam int IDX_W = $clog2(MAX_PROCS);
   localparam int CNT_W = $clog2(MAX_PROCS + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PROCS);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_UPDATE = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [15:0] arr_mem  [MAX_PROCS];
   logic [13:0] rem_mem  [MAX_PROCS];
   logic [15:0] wait_mem [MAX_PROCS];

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] unfin_ff, unfin_in;
   logic [15:0]      time_ff, time_in;
   logic [CNT_W-1:0] rd_idx_ff, rd_idx_in;
   logic             d_vld_ff, d_vld_in;
   logic [IDX_W-1:0] d_idx_ff, d_idx_in;
   logic             found_ff, found_in;
   logic [IDX_W-1:0] sel_ff, sel_in;
   logic [13:0]      best_ff, best_in;
   logic [1:0]       res_kind_ff, res_kind_in;
   logic [IDX_W-1:0] res_id_ff, res_id_in;
   logic             fin_ff, fin_in;
   logic [15:0]      wait_ff, wait_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [1:0]       rsp_kind_ff;
   logic [3:0]       rsp_id_ff;
   logic [15:0]      rsp_tick_ff;
   logic             rsp_fin_ff;
   logic [15:0]      rsp_ftime_ff;
   logic [15:0]      rsp_wait_ff;
   logic             rsp_done_ff;

   logic [15:0]      arr_q_ff;
   logic [13:0]      rem_q_ff;
   logic [15:0]      wait_q_ff;

   logic             issue;
   logic             pass_end;
   logic [IDX_W-1:0] rd_addr;
   logic             ready_q;
   logic             load_we;
   logic             rem_we;
   logic             wait_we;
   logic [IDX_W-1:0] wr_addr;
   logic [13:0]      rem_wd;
   logic [15:0]      wait_wd;
   logic             take_out;
   logic             load_reject;
   logic [CNT_W-1:0] unfin_next;
   logic [IDX_W+3:0] id_wide;

   assign req_ready = (state_ff == ST_IDLE);
   assign issue     = (rd_idx_ff < count_ff);
   assign pass_end  = !issue && !d_vld_ff;
   assign rd_addr   = rd_idx_ff[IDX_W-1:0];
   assign ready_q   = (arr_q_ff <= time_ff) && (rem_q_ff != 14'd0);
   assign take_out  = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_ready);
   assign load_reject = (req_burst == 14'd0) || (req_burst >= srtf_pkg::BURST_LIMIT) ||
                        (count_ff == CNT_MAX);
   assign id_wide   = {4'd0, res_id_ff};

   always_ff @(posedge clock) begin
      if (load_we) begin
         arr_mem[wr_addr] <= req_arrival;
      end
      arr_q_ff <= arr_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (rem_we) begin
         rem_mem[wr_addr] <= rem_wd;
      end
      rem_q_ff <= rem_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (wait_we) begin
         wait_mem[wr_addr] <= wait_wd;
      end
      wait_q_ff <= wait_mem[rd_addr];
   end

   always_comb begin
      state_in    = state_ff;
      rd_idx_in   = rd_idx_ff;
      d_vld_in    = 1'b0;
      d_idx_in    = d_idx_ff;
      found_in    = found_ff;
      sel_in      = sel_ff;
      best_in     = best_ff;
      res_kind_in = res_kind_ff;
      res_id_in   = res_id_ff;
      fin_in      = fin_ff;
      wait_in     = wait_ff;
      load_we     = 1'b0;
      rem_we      = 1'b0;
      wait_we     = 1'b0;
      wr_addr     = d_idx_ff;
      rem_wd      = req_burst;
      wait_wd     = 16'd0;
      case (state_ff)
         ST_IDLE: begin
            wr_addr = count_ff[IDX_W-1:0];
            if (req_valid) begin
               fin_in  = 1'b0;
               wait_in = 16'd0;
               if (req_op == srtf_pkg::OP_LOAD) begin
                  state_in = ST_FINISH;
                  if (load_reject) begin
                     res_kind_in = srtf_pkg::KIND_LOAD_REJECT;
                     res_id_in   = '0;
                  end else begin
                     res_kind_in = srtf_pkg::KIND_LOAD_OK;
                     res_id_in   = count_ff[IDX_W-1:0];
                     load_we     = 1'b1;
                     rem_we      = 1'b1;
                     wait_we     = 1'b1;
                  end
               end else begin
                  state_in  = ST_SCAN;
                  rd_idx_in = '0;
                  found_in  = 1'b0;
               end
            end
         end
         ST_SCAN: begin
            if (issue) begin
               rd_idx_in = rd_idx_ff + 1'b1;
            end
            d_vld_in = issue;
            d_idx_in = rd_addr;
            if (d_vld_ff && ready_q && (!found_ff || (rem_q_ff < best_ff))) begin
               found_in = 1'b1;
               sel_in   = d_idx_ff;
               best_in  = rem_q_ff;
            end
            if (pass_end) begin
               if (found_ff) begin
                  state_in  = ST_UPDATE;
                  rd_idx_in = '0;
               end else begin
                  state_in    = ST_FINISH;
                  res_kind_in = srtf_pkg::KIND_IDLE_TICK;
                  res_id_in   = '0;
               end
            end
         end
         ST_UPDATE: begin
            if (issue) begin
               rd_idx_in = rd_idx_ff + 1'b1;
            end
            d_vld_in = issue;
            d_idx_in = rd_addr;
            rem_wd   = rem_q_ff - 14'd1;
            wait_wd  = wait_q_ff + 16'd1;
            if (d_vld_ff) begin
               if (d_idx_ff == sel_ff) begin
                  rem_we  = 1'b1;
                  fin_in  = (rem_q_ff == 14'd1);
                  wait_in = wait_q_ff;
               end else if (ready_q && (wait_q_ff != srtf_pkg::WAIT_MAX)) begin
                  wait_we = 1'b1;
               end
            end
            if (pass_end) begin
               state_in    = ST_FINISH;
               res_kind_in = srtf_pkg::KIND_RAN;
               res_id_in   = sel_ff;
            end
         end
         ST_FINISH: begin
            if (take_out) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      count_in = count_ff;
      unfin_in = unfin_ff;
      time_in  = time_ff;
      if (take_out) begin
         if (res_kind_ff == srtf_pkg::KIND_LOAD_OK) begin
            count_in = count_ff + 1'b1;
            unfin_in = unfin_ff + 1'b1;
         end else if (res_kind_ff != srtf_pkg::KIND_LOAD_REJECT) begin
            if (time_ff != srtf_pkg::TIME_MAX) begin
               time_in = time_ff + 16'd1;
            end
            if (fin_ff && (unfin_ff != '0)) begin
               unfin_in = unfin_ff - 1'b1;
            end
         end
      end
      unfin_next = unfin_in;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (take_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         unfin_ff     <= '0;
         time_ff      <= 16'd0;
         rsp_valid_ff <= 1'b0;
         d_vld_ff     <= 1'b0;
         found_ff     <= 1'b0;
         rd_idx_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         unfin_ff     <= unfin_in;
         time_ff      <= time_in;
         rsp_valid_ff <= rsp_valid_in;
         d_vld_ff     <= d_vld_in;
         found_ff     <= found_in;
         rd_idx_ff    <= rd_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      d_idx_ff    <= d_idx_in;
      sel_ff      <= sel_in;
      best_ff     <= best_in;
      res_kind_ff <= res_kind_in;
      res_id_ff   <= res_id_in;
      fin_ff      <= fin_in;
      wait_ff     <= wait_in;
      if (take_out) begin
         rsp_kind_ff  <= res_kind_ff;
         rsp_id_ff    <= id_wide[3:0];
         rsp_tick_ff  <= time_ff;
         rsp_fin_ff   <= fin_ff;
         rsp_ftime_ff <= !fin_ff ? 16'd0 :
                         (time_ff == srtf_pkg::TIME_MAX) ? time_ff : time_ff + 16'd1;
         rsp_wait_ff  <= fin_ff ? wait_ff : 16'd0;
         rsp_done_ff  <= (unfin_next == '0);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_proc_id     = rsp_id_ff;
   assign rsp_tick_time   = rsp_tick_ff;
   assign rsp_finished    = rsp_fin_ff;
   assign rsp_finish_time = rsp_ftime_ff;
   assign rsp_wait_total  = rsp_wait_ff;
   assign rsp_all_done    = rsp_done_ff;

   `ASSERT_SAME(a_unfin_le_count, clock, reset, 1'b1, unfin_ff <= count_ff,
                "unfinished above loaded count")
   `ASSERT_SAME(a_rem_write_sel, clock, reset, rem_we && (state_ff == ST_UPDATE),
                d_idx_ff == sel_ff, "remaining written off the selected entry")
   `ASSERT_SAME(a_found_nonzero, clock, reset, state_ff == ST_UPDATE,
                found_ff && (best_ff != 14'd0), "update pass without a ready process")
   `ASSERT_NEXT(a_req_leaves_idle, clock, reset, req_valid && req_ready,
                state_ff != ST_IDLE, "accepted request left sequencer idle")

endmodule

// ----- verif/srtf_scheduler_tick_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scheduler testbench
// Drives load and tick requests into the shortest-remaining-time scheduler
// with random idle and stall cycles on both channels. Each response is checked
// field by field against the directed table or a behavioral scheduler kept in
// step inside this bench. A directed table comes first, then random traffic,
// and finally loads that fill and overflow the process table, then ticks.
// ----------------------------------------------------------------------------
module testbench;

   localparam int N_SLOTS      = 16;
   localparam int RANDOM_ITEMS = 1400;
   localparam int CYCLE_LIMIT  = 10_000_000;

   typedef struct packed {
      logic [1:0]  kind;
      logic [3:0]  proc_id;
      logic [15:0] tick_time;
      logic        finished;
      logic [15:0] finish_time;
      logic [15:0] wait_total;
      logic        all_done;
   } sched_rsp_type;

   typedef struct packed {
      logic          op;
      logic [15:0]   arrival;
      logic [13:0]   burst;
      bit            typed;
      sched_rsp_type rsp;
   } plan_row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_op;
   logic [15:0] req_arrival;
   logic [13:0] req_burst;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [1:0]  rsp_kind;
   logic [3:0]  rsp_proc_id;
   logic [15:0] rsp_tick_time;
   logic        rsp_finished;
   logic [15:0] rsp_finish_time;
   logic [15:0] rsp_wait_total;
   logic        rsp_all_done;

   logic [15:0] slot_arrival [N_SLOTS];
   logic [13:0] slot_remaining [N_SLOTS];
   logic [15:0] slot_waited [N_SLOTS];
   int          loaded_count = 0;
   int          open_count = 0;
   logic [15:0] sched_now = 16'd0;

   sched_rsp_type pending_rsp [$];
   sched_rsp_type oldest_rsp;
   plan_row_type  directed_plan [$];
   bit            steady_mode = 1'b0;
   int            err_count = 0;
   int            cycle_count = 0;

   srtf_scheduler_tick #(
      .MAX_PROCS(N_SLOTS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_op(req_op),
      .req_arrival(req_arrival),
      .req_burst(req_burst),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_kind(rsp_kind),
      .rsp_proc_id(rsp_proc_id),
      .rsp_tick_time(rsp_tick_time),
      .rsp_finished(rsp_finished),
      .rsp_finish_time(rsp_finish_time),
      .rsp_wait_total(rsp_wait_total),
      .rsp_all_done(rsp_all_done)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic bit slot_ready(input int i);
      return slot_arrival[i] <= sched_now && slot_remaining[i] != 14'd0;
   endfunction

   function automatic sched_rsp_type predict_schedule(input logic op,
                                                      input logic [15:0] arr,
                                                      input logic [13:0] burst);
      sched_rsp_type r;
      int i;
      int sel;
      r = '0;
      r.tick_time = sched_now;
      sel = -1;
      if (op == srtf_pkg::OP_LOAD) begin
         if (burst == 14'd0 || burst >= srtf_pkg::BURST_LIMIT || loaded_count >= N_SLOTS) begin
            r.kind = srtf_pkg::KIND_LOAD_REJECT;
         end else begin
            slot_arrival[loaded_count] = arr;
            slot_remaining[loaded_count] = burst;
            slot_waited[loaded_count] = 16'd0;
            r.kind = srtf_pkg::KIND_LOAD_OK;
            r.proc_id = 4'(loaded_count);
            loaded_count++;
            open_count++;
         end
      end else begin
         for (i = 0; i < loaded_count; i++) begin
            if (slot_ready(i) && (sel < 0 || slot_remaining[i] < slot_remaining[sel]))
               sel = i;
         end
         if (sel < 0) begin
            r.kind = srtf_pkg::KIND_IDLE_TICK;
         end else begin
            for (i = 0; i < loaded_count; i++) begin
               if (i != sel && slot_ready(i) && slot_waited[i] != srtf_pkg::WAIT_MAX)
                  slot_waited[i]++;
            end
            slot_remaining[sel]--;
            r.kind = srtf_pkg::KIND_RAN;
            r.proc_id = 4'(sel);
            if (slot_remaining[sel] == 14'd0) begin
               r.finished = 1'b1;
               r.finish_time = (sched_now == srtf_pkg::TIME_MAX) ? srtf_pkg::TIME_MAX
                                                                 : sched_now + 16'd1;
               r.wait_total = slot_waited[sel];
               open_count--;
            end
         end
         if (sched_now != srtf_pkg::TIME_MAX)
            sched_now++;
      end
      r.all_done = (open_count == 0);
      return r;
   endfunction

   function automatic plan_row_type plan_row(input logic op, input logic [15:0] arr,
                                             input logic [13:0] burst, input bit typed,
                                             input logic [1:0] kind, input int id,
                                             input int tick, input bit fin, input int ftime,
                                             input int wt, input bit done);
      plan_row_type p;
      p.op = op;
      p.arrival = arr;
      p.burst = burst;
      p.typed = typed;
      p.rsp.kind = kind;
      p.rsp.proc_id = 4'(id);
      p.rsp.tick_time = 16'(tick);
      p.rsp.finished = fin;
      p.rsp.finish_time = 16'(ftime);
      p.rsp.wait_total = 16'(wt);
      p.rsp.all_done = done;
      return p;
   endfunction

   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70)
         return $urandom_range(1, 3);
      if (r < 95)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic report_error(input string msg);
      $display("ERROR at cycle %0d: %s", cycle_count, msg);
      err_count++;
   endtask

   task automatic check_field(input string name, input logic [15:0] got,
                              input logic [15:0] want);
      if (got !== want)
         report_error($sformatf("%s is %0h, expected %0h", name, got, want));
   endtask

   task automatic issue_request(input logic op, input logic [15:0] arr,
                                input logic [13:0] burst, input bit typed,
                                input sched_rsp_type typed_rsp);
      int gap;
      sched_rsp_type predicted;
      gap = (steady_mode || $urandom_range(0, 1) == 0) ? 0 : idle_len();
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_op <= op;
      req_arrival <= arr;
      req_burst <= burst;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = predict_schedule(op, arr, burst);
      pending_rsp.push_back(typed ? typed_rsp : predicted);
   endtask

   task automatic wait_for_responses();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   initial begin
      int hold;
      bit stalling;
      hold = 0;
      stalling = 1'b0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (steady_mode) begin
            hold = 0;
            stalling = 1'b0;
         end else begin
            if (hold == 0) begin
               stalling = !stalling && ($urandom_range(0, 2) == 0);
               hold = stalling ? idle_len() : $urandom_range(1, 12);
            end
            hold--;
         end
         rsp_ready <= !stalling;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            report_error("response with no request outstanding");
         end else begin
            oldest_rsp = pending_rsp.pop_front();
            check_field("kind", 16'(rsp_kind), 16'(oldest_rsp.kind));
            check_field("proc_id", 16'(rsp_proc_id), 16'(oldest_rsp.proc_id));
            check_field("tick_time", rsp_tick_time, oldest_rsp.tick_time);
            check_field("finished", 16'(rsp_finished), 16'(oldest_rsp.finished));
            check_field("finish_time", rsp_finish_time, oldest_rsp.finish_time);
            check_field("wait_total", rsp_wait_total, oldest_rsp.wait_total);
            check_field("all_done", 16'(rsp_all_done), 16'(oldest_rsp.all_done));
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timeout after %0d cycles", cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      int idx;
      int cap;
      int a;
      logic op;
      logic [15:0] arr;
      logic [13:0] brst;

      reset = 1'b1;
      req_valid = 1'b0;
      req_op = srtf_pkg::OP_LOAD;
      req_arrival = 16'd0;
      req_burst = 14'd0;

      //         op, arrival, burst, typed / kind, id, tick, fin, ftime, wait, done
      directed_plan.push_back(plan_row(srtf_pkg::OP_TICK, 16'h0000, 14'd0,
                                       1, srtf_pkg::KIND_IDLE_TICK, 0, 0, 0, 0, 0, 1));
      directed_plan.push_back(plan_row(srtf_pkg::OP_LOAD, 16'h0000, 14'd0,
                                       1, srtf_pkg::KIND_LOAD_REJECT, 0, 1, 0, 0, 0, 1));
      directed_plan.push_back(plan_row(srtf_pkg::OP_LOAD, 16'h0005, 14'd10000,
                                       1, srtf_pkg::KIND_LOAD_REJECT, 0, 1, 0, 0, 0, 1));
      directed_plan.push_back(plan_row(srtf_pkg::OP_LOAD, 16'hFFFF, 14'h3FFF,
                                       1, srtf_pkg::KIND_LOAD_REJECT, 0, 1, 0, 0, 0, 1));
      directed_plan.push_back(plan_row(srtf_pkg::OP_LOAD, 16'h0000, 14'd1,
                                       1, srtf_pkg::KIND_LOAD_OK, 0, 1, 0, 0, 0, 0));
      directed_plan.push_back(plan_row(srtf_pkg::OP_TICK, 16'hFFFF, 14'h3FFF,
                                       1, srtf_pkg::KIND_RAN, 0, 1, 1, 2, 0, 1));
      directed_plan.push_back(plan_row(srtf_pkg::OP_LOAD, 16'hFFFF, 14'd3,
                                       1, srtf_pkg::KIND_LOAD_OK, 1, 2, 0, 0, 0, 0));
      directed_plan.push_back(plan_row(srtf_pkg::OP_LOAD, 16'hFFFF, 14'd9999,
                                       1, srtf_pkg::KIND_LOAD_OK, 2, 2, 0, 0, 0, 0));
      directed_plan.push_back(plan_row(srtf_pkg::OP_TICK, 16'h0000, 14'd0,
                                       1, srtf_pkg::KIND_IDLE_TICK, 0, 2, 0, 0, 0, 0));
      directed_plan.push_back(plan_row(srtf_pkg::OP_LOAD, 16'h0000, 14'd4,
                                       0, srtf_pkg::KIND_LOAD_OK, 0, 0, 0, 0, 0, 0));
      directed_plan.push_back(plan_row(srtf_pkg::OP_LOAD, 16'h0000, 14'd4,
                                       0, srtf_pkg::KIND_LOAD_OK, 0, 0, 0, 0, 0, 0));
      directed_plan.push_back(plan_row(srtf_pkg::OP_LOAD, 16'h0006, 14'd2,
                                       0, srtf_pkg::KIND_LOAD_OK, 0, 0, 0, 0, 0, 0));
      for (idx = 0; idx < 12; idx++)
         directed_plan.push_back(plan_row(srtf_pkg::OP_TICK,
                                          (idx % 2) ? 16'hA5A5 : 16'h5A5A,
                                          (idx % 2) ? 14'h2AAA : 14'h1555,
                                          0, srtf_pkg::KIND_RAN, 0, 0, 0, 0, 0, 0));

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_plan[i])
         issue_request(directed_plan[i].op, directed_plan[i].arrival, directed_plan[i].burst,
                       directed_plan[i].typed, directed_plan[i].rsp);

      for (idx = 0; idx < RANDOM_ITEMS; idx++) begin
         steady_mode = (idx % 400) < 50;
         cap = 7 + (idx * 4) / RANDOM_ITEMS;
         arr = 16'($urandom);
         brst = 14'($urandom);
         op = srtf_pkg::OP_TICK;
         if ($urandom_range(0, 99) < 24) begin
            op = srtf_pkg::OP_LOAD;
            if ($urandom_range(0, 9) < 6 && loaded_count < cap) begin
               if ($urandom_range(0, 7) != 0) begin
                  a = sched_now + $urandom_range(0, 40);
                  arr = (a > 65535) ? 16'hFFFF : a[15:0];
               end
               brst = ($urandom_range(0, 9) == 0) ? 14'($urandom_range(1, 2000))
                                                  : 14'($urandom_range(1, 24));
            end else if ($urandom_range(0, 1) == 0) begin
               brst = 14'd0;
            end else begin
               brst = 14'($urandom_range(srtf_pkg::BURST_LIMIT, 16383));
            end
         end
         issue_request(op, arr, brst, 1'b0, '0);
      end

      wait_for_responses();
      steady_mode = 1'b0;
      while (loaded_count < N_SLOTS)
         issue_request(srtf_pkg::OP_LOAD, 16'($urandom), 14'($urandom_range(1, 30)),
                       1'b0, '0);
      repeat (3) issue_request(srtf_pkg::OP_LOAD, 16'($urandom),
                               14'($urandom_range(1, 9999)), 1'b0, '0);
      repeat (60) issue_request(srtf_pkg::OP_TICK, 16'($urandom), 14'($urandom), 1'b0, '0);

      wait_for_responses();
      repeat (2 * N_SLOTS + 10) @(posedge clock);
      if (err_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
